>>> src/cistk_pkg.sv
// ----------------------------------------------------------------------------
// CAN identifier statistics package
// Shared widths, default parameters, command codes and the control bundle
// of the top-K ranking list.
// ----------------------------------------------------------------------------
package cistk_pkg;

  localparam int unsigned ID_BITS_DEF = 11;
  localparam int unsigned TOP_K_DEF   = 5;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned RAW_ID_W = 32;
  localparam int unsigned DLC_W    = 4;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned RID_W    = 11;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned DSUM_W   = 36;
  localparam int unsigned TOTAL_W  = 48;
  localparam int unsigned ENTRY_W  = COUNT_W + DSUM_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_FRAME  = 2'd0,
    MODE_REPORT = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_e;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_ENTRY  = 1'b1;

  typedef struct packed {
    logic clr;
    logic ins;
    logic pop;
  } topk_ctrl_t;

endpackage

>>> src/cistk_topk.sv
// ----------------------------------------------------------------------------
// Top-K ranking list
// Keeps the largest counts seen during a table scan in descending order,
// lower identifiers first on equal counts, and shifts them out one by one.
// ----------------------------------------------------------------------------
module cistk_topk #(
  parameter int unsigned ID_BITS = cistk_pkg::ID_BITS_DEF,
  parameter int unsigned TOP_K   = cistk_pkg::TOP_K_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cistk_pkg::topk_ctrl_t          ctrl_i,
  input  logic [ID_BITS-1:0]             ins_id_i,
  input  logic [cistk_pkg::COUNT_W-1:0]  ins_cnt_i,
  input  logic [cistk_pkg::DSUM_W-1:0]   ins_dsum_i,
  output logic [ID_BITS-1:0]             head_id_o,
  output logic [cistk_pkg::COUNT_W-1:0]  head_cnt_o,
  output logic [cistk_pkg::DSUM_W-1:0]   head_dsum_o,
  output logic                           head_nz_o,
  output logic                           next_nz_o
);
  import cistk_pkg::*;

  logic [ID_BITS-1:0] id_q   [TOP_K];
  logic [COUNT_W-1:0] cnt_q  [TOP_K];
  logic [DSUM_W-1:0]  dsum_q [TOP_K];
  logic [TOP_K-1:0]   gt;

  for (genvar j = 0; j < TOP_K; j++) begin : g_slot
    assign gt[j] = ins_cnt_i > cnt_q[j];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        id_q[j]   <= '0;
        cnt_q[j]  <= '0;
        dsum_q[j] <= '0;
      end else if (ctrl_i.clr) begin
        id_q[j]   <= '0;
        cnt_q[j]  <= '0;
        dsum_q[j] <= '0;
      end else if (ctrl_i.pop) begin
        if (j + 1 < TOP_K) begin
          id_q[j]   <= id_q[(j + 1) % TOP_K];
          cnt_q[j]  <= cnt_q[(j + 1) % TOP_K];
          dsum_q[j] <= dsum_q[(j + 1) % TOP_K];
        end else begin
          id_q[j]   <= '0;
          cnt_q[j]  <= '0;
          dsum_q[j] <= '0;
        end
      end else if (ctrl_i.ins) begin
        if (j > 0 && gt[(j + TOP_K - 1) % TOP_K]) begin
          id_q[j]   <= id_q[(j + TOP_K - 1) % TOP_K];
          cnt_q[j]  <= cnt_q[(j + TOP_K - 1) % TOP_K];
          dsum_q[j] <= dsum_q[(j + TOP_K - 1) % TOP_K];
        end else if (gt[j]) begin
          id_q[j]   <= ins_id_i;
          cnt_q[j]  <= ins_cnt_i;
          dsum_q[j] <= ins_dsum_i;
        end
      end
    end
  end

  assign head_id_o   = id_q[0];
  assign head_cnt_o  = cnt_q[0];
  assign head_dsum_o = dsum_q[0];
  assign head_nz_o   = |cnt_q[0];

  if (TOP_K > 1) begin : g_next
    assign next_nz_o = |cnt_q[1 % TOP_K];
  end else begin : g_no_next
    assign next_nz_o = 1'b0;
  end

endmodule

>>> src/can_id_stats_top_k_core.sv
// ----------------------------------------------------------------------------
// CAN identifier statistics with top-K report
// An item is transferred when start_i is high and busy_o is low. Mode frame
// adds one frame to the entry of its identifier, mode clear zeroes the
// table and records the start time, mode report emits a header followed by
// the ranked identifiers. Results appear for one cycle with result_valid_o;
// the receiver cannot stall them, and last_o marks the end of a report.
//
// Steps, with a table of 2^ID_BITS entries held in one single-port-read
// synchronous memory:
//   frame update: read, then modify and write back;
//   clear:        one entry zeroed per cycle;
//   report:       a scan of all 2^ID_BITS entries, then one result per cycle,
//                 header first, up to TOP_K + 1 results in all.
// One entry is read per cycle through the memory read port.
// After reset the block sweeps the table to zero and
// holds busy_o high meanwhile. The final strobe of a report may coincide
// with the transfer of the next item.
// ----------------------------------------------------------------------------
module can_id_stats_top_k_core #(
  parameter int unsigned ID_BITS = cistk_pkg::ID_BITS_DEF,
  parameter int unsigned TOP_K   = cistk_pkg::TOP_K_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [cistk_pkg::MODE_W-1:0]    mode_i,
  input  logic [cistk_pkg::RAW_ID_W-1:0]  raw_id_i,
  input  logic [cistk_pkg::DLC_W-1:0]     frame_dlc_i,
  input  logic [cistk_pkg::TIME_W-1:0]    now_seconds_i,
  output logic                            result_valid_o,
  output logic                            kind_o,
  output logic [cistk_pkg::RID_W-1:0]     ranked_id_o,
  output logic [cistk_pkg::COUNT_W-1:0]   ranked_count_o,
  output logic [cistk_pkg::DSUM_W-1:0]    ranked_dlc_sum_o,
  output logic [cistk_pkg::TOTAL_W-1:0]   total_frames_o,
  output logic [cistk_pkg::TIME_W-1:0]    elapsed_seconds_o,
  output logic                            last_o
);
  import cistk_pkg::*;

  localparam int unsigned DEPTH = 1 << ID_BITS;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_SCAN,
    ST_SCAN_END,
    ST_HDR,
    ST_ENT
  } state_e;

  state_e             state_q;
  logic [ID_BITS-1:0] addr_q;
  logic [ID_BITS-1:0] pipe_id_q;
  logic               pipe_vld_q;
  logic [DLC_W-1:0]   dlc_q;
  logic [TOTAL_W-1:0] frame_total_q;
  logic [TIME_W-1:0]  start_stamp_q;
  logic [TIME_W-1:0]  elapsed_q;

  logic               valid_q;
  logic               kind_q;
  logic [RID_W-1:0]   rid_q;
  logic [COUNT_W-1:0] rcnt_q;
  logic [DSUM_W-1:0]  rdsum_q;
  logic [TOTAL_W-1:0] rtotal_q;
  logic [TIME_W-1:0]  relapsed_q;
  logic               last_q;

  logic [ENTRY_W-1:0] table_q [DEPTH];
  logic [ENTRY_W-1:0] rd_data_q;
  logic               mem_we;
  logic [ID_BITS-1:0] mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ID_BITS-1:0] mem_raddr;

  logic [COUNT_W-1:0] rd_cnt;
  logic [DSUM_W-1:0]  rd_dsum;
  logic [COUNT_W-1:0] new_cnt;
  logic [DSUM_W:0]    dsum_sum;
  logic [DSUM_W-1:0]  new_dsum;
  logic               accept;

  topk_ctrl_t         tk_ctrl;
  logic [ID_BITS-1:0] head_id;
  logic [COUNT_W-1:0] head_cnt;
  logic [DSUM_W-1:0]  head_dsum;
  logic               head_nz;
  logic               next_nz;
  logic [RID_W+ID_BITS-1:0] head_id_ext;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  assign rd_cnt  = rd_data_q[ENTRY_W-1:DSUM_W];
  assign rd_dsum = rd_data_q[DSUM_W-1:0];
  assign new_cnt = (rd_cnt == '1) ? rd_cnt : rd_cnt + COUNT_W'(1);
  assign dsum_sum = {1'b0, rd_dsum} + (DSUM_W + 1)'(dlc_q);
  assign new_dsum = dsum_sum[DSUM_W] ? '1 : dsum_sum[DSUM_W-1:0];
  assign head_id_ext = {{RID_W{1'b0}}, head_id};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = '0;
    mem_raddr = addr_q;
    tk_ctrl   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        mem_raddr   = raw_id_i[ID_BITS-1:0];
        tk_ctrl.clr = accept && (mode_i == MODE_REPORT);
      end
      ST_UPD: begin
        mem_we    = 1'b1;
        mem_wdata = {new_cnt, new_dsum};
      end
      ST_ENT: begin
        tk_ctrl.pop = 1'b1;
      end
      default: begin
      end
    endcase
    tk_ctrl.ins = pipe_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= table_q[mem_raddr];
  end

  cistk_topk #(
    .ID_BITS (ID_BITS),
    .TOP_K   (TOP_K)
  ) u_topk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (tk_ctrl),
    .ins_id_i    (pipe_id_q),
    .ins_cnt_i   (rd_cnt),
    .ins_dsum_i  (rd_dsum),
    .head_id_o   (head_id),
    .head_cnt_o  (head_cnt),
    .head_dsum_o (head_dsum),
    .head_nz_o   (head_nz),
    .next_nz_o   (next_nz)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      addr_q        <= '0;
      pipe_id_q     <= '0;
      pipe_vld_q    <= 1'b0;
      dlc_q         <= '0;
      frame_total_q <= '0;
      start_stamp_q <= '0;
      elapsed_q     <= '0;
      valid_q       <= 1'b0;
      kind_q        <= KIND_HEADER;
      rid_q         <= '0;
      rcnt_q        <= '0;
      rdsum_q       <= '0;
      rtotal_q      <= '0;
      relapsed_q    <= '0;
      last_q        <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          addr_q <= addr_q + ID_BITS'(1);
          if (addr_q == '1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            unique case (mode_i)
              MODE_FRAME: begin
                addr_q  <= raw_id_i[ID_BITS-1:0];
                dlc_q   <= frame_dlc_i;
                state_q <= ST_UPD;
              end
              MODE_CLEAR: begin
                start_stamp_q <= now_seconds_i;
                frame_total_q <= '0;
                addr_q        <= '0;
                state_q       <= ST_CLEAR;
              end
              MODE_REPORT: begin
                elapsed_q <= now_seconds_i - start_stamp_q;
                addr_q    <= '0;
                state_q   <= ST_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        ST_UPD: begin
          if (frame_total_q != '1) begin
            frame_total_q <= frame_total_q + TOTAL_W'(1);
          end
          state_q <= ST_IDLE;
        end
        ST_SCAN: begin
          pipe_vld_q <= 1'b1;
          pipe_id_q  <= addr_q;
          addr_q     <= addr_q + ID_BITS'(1);
          if (addr_q == '1) begin
            state_q <= ST_SCAN_END;
          end
        end
        ST_SCAN_END: begin
          pipe_vld_q <= 1'b0;
          state_q    <= ST_HDR;
        end
        ST_HDR: begin
          valid_q    <= 1'b1;
          kind_q     <= KIND_HEADER;
          rid_q      <= '0;
          rcnt_q     <= '0;
          rdsum_q    <= '0;
          rtotal_q   <= frame_total_q;
          relapsed_q <= elapsed_q;
          last_q     <= !head_nz;
          state_q    <= head_nz ? ST_ENT : ST_IDLE;
        end
        ST_ENT: begin
          valid_q    <= 1'b1;
          kind_q     <= KIND_ENTRY;
          rid_q      <= head_id_ext[RID_W-1:0];
          rcnt_q     <= head_cnt;
          rdsum_q    <= head_dsum;
          rtotal_q   <= '0;
          relapsed_q <= '0;
          last_q     <= !next_nz;
          if (!next_nz) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign result_valid_o    = valid_q;
  assign kind_o            = kind_q;
  assign ranked_id_o       = rid_q;
  assign ranked_count_o    = rcnt_q;
  assign ranked_dlc_sum_o  = rdsum_q;
  assign total_frames_o    = rtotal_q;
  assign elapsed_seconds_o = relapsed_q;
  assign last_o            = last_q;

endmodule
